// File: sv/byte_stuffed_frame_encoder_macros.svh
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder assertion macros
// Shorthand for the concurrent checks of the top level; expects clk and rst.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH
`define BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH

// Implication in the same cycle.
`define BSFE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define BSFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define BSFE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: sv/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder package
// Shared codes, constants, run and status types and the escape function.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  typedef enum logic [1:0] {
    OP_MSG_HDR = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_IMG_HDR = 2'd2,
    OP_PIXEL   = 2'd3
  } opcode_t;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_BYTE = 1'b0,
    CFG_IMAGE_CMD = 1'b1
  } cfg_idx_t;

  localparam logic [7:0]  HEAD_RESET   = 8'h7A;
  localparam logic [7:0]  IMGCMD_RESET = 8'h00;
  localparam logic [7:0]  FLAG_BYTE    = 8'h7A;
  localparam logic [7:0]  ESC_BYTE     = 8'h7B;
  localparam logic [7:0]  ESC_FLAG_SUB = 8'h00;
  localparam logic [7:0]  ESC_ESC_SUB  = 8'h01;
  localparam logic [18:0] MAX_PIXELS   = 19'd524280;

  localparam int RUN_MAX   = 9;
  localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);

  typedef struct packed {
    logic [1:0][7:0] data;   // data[0] goes out first
    logic            two;
  } esc_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] data;
    logic [RUN_LEN_W-1:0]    len;
    logic                    ends_frame;
  } run_t;

  typedef struct packed {
    logic frame_open;
    logic image_mode;
    logic bytes_zero;
    logic pixels_zero;
  } fstat_t;

  typedef struct packed {
    logic pending;
    logic free;
  } rstat_t;

  function automatic esc_t escape(input logic [7:0] b);
    esc_t e;
    e.two     = 1'b0;
    e.data[0] = b;
    e.data[1] = 8'h00;
    if (b == FLAG_BYTE) begin
      e.two     = 1'b1;
      e.data[0] = ESC_BYTE;
      e.data[1] = ESC_FLAG_SUB;
    end else if (b == ESC_BYTE) begin
      e.two     = 1'b1;
      e.data[0] = ESC_BYTE;
      e.data[1] = ESC_ESC_SUB;
    end
    return e;
  endfunction

endpackage

// File: sv/bsfe_cfg.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder configuration registers
// Holds the head byte and the image command byte.
// ----------------------------------------------------------------------------
module bsfe_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                     wr_data,
  output logic [7:0]                     head_byte,
  output logic [7:0]                     image_command
);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte     <= bsfe_pkg::HEAD_RESET;
      image_command <= bsfe_pkg::IMGCMD_RESET;
    end else if (wr_en) begin
      case (bsfe_pkg::cfg_idx_t'(wr_index))
        bsfe_pkg::CFG_HEAD_BYTE: head_byte     <= wr_data;
        bsfe_pkg::CFG_IMAGE_CMD: image_command <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/bsfe_frame_ctl.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder frame control
// Frame state and the encoding of one input word into a run of bytes.
// ----------------------------------------------------------------------------
module bsfe_frame_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  bsfe_pkg::opcode_t   opcode,
  input  logic [7:0]          frame_type,
  input  logic [7:0]          frame_id,
  input  logic [15:0]         payload_length,
  input  logic [7:0]          data_byte,
  input  logic [18:0]         pixel_count,
  input  logic                pixel_on,
  input  logic [7:0]          head_byte,
  input  logic [7:0]          image_command,
  output bsfe_pkg::run_t      run,
  output bsfe_pkg::fstat_t    status
);

  logic [15:0] bytes_left, bytes_left_next;
  logic [18:0] pixels_left, pixels_left_next;
  logic [7:0]  pack_register, pack_register_next;
  logic [2:0]  bit_position, bit_position_next;
  logic        frame_open, frame_open_next;
  logic        image_mode, image_mode_next;

  logic                     is_img;
  logic [18:0]              count_sat;
  logic [18:0]              count_rnd;
  logic [15:0]              hdr_len;
  logic [3:0][7:0]          hdr_src;
  bsfe_pkg::run_t           hdr_run;
  bsfe_pkg::esc_t           esc;
  logic [bsfe_pkg::RUN_LEN_W-1:0] pos;
  logic [7:0]               single;
  bsfe_pkg::esc_t           single_esc;
  logic [7:0]               packed_byte;
  logic [2:0]               bp_inc;
  logic [18:0]              pl_dec;
  logic [15:0]              bl_dec;

  // Header run: head byte raw, then type, id, length low, length high escaped.
  always_comb begin
    is_img    = (opcode == bsfe_pkg::OP_IMG_HDR);
    count_sat = (pixel_count > bsfe_pkg::MAX_PIXELS) ? bsfe_pkg::MAX_PIXELS : pixel_count;
    count_rnd = count_sat + 19'd7;
    hdr_len   = is_img ? count_rnd[18:3] : payload_length;
    hdr_src[0] = is_img ? image_command : frame_type;
    hdr_src[1] = frame_id;
    hdr_src[2] = hdr_len[7:0];
    hdr_src[3] = hdr_len[15:8];
    hdr_run      = '0;
    hdr_run.data[0] = head_byte;
    pos = bsfe_pkg::RUN_LEN_W'(1);
    for (int i = 0; i < 4; i++) begin
      esc = bsfe_pkg::escape(hdr_src[i]);
      hdr_run.data[pos] = esc.data[0];
      if (esc.two) begin
        hdr_run.data[pos + bsfe_pkg::RUN_LEN_W'(1)] = esc.data[1];
        pos = pos + bsfe_pkg::RUN_LEN_W'(2);
      end else begin
        pos = pos + bsfe_pkg::RUN_LEN_W'(1);
      end
    end
    hdr_run.len        = pos;
    hdr_run.ends_frame = (hdr_len == 16'd0);
  end

  always_comb begin
    packed_byte = pack_register | (pixel_on ? (8'h80 >> bit_position) : 8'h00);
    bp_inc      = bit_position + 3'd1;
    pl_dec      = pixels_left - 19'd1;
    bl_dec      = bytes_left - 16'd1;
    single      = (opcode == bsfe_pkg::OP_PIXEL) ? packed_byte : data_byte;
    single_esc  = bsfe_pkg::escape(single);
  end

  always_comb begin
    bytes_left_next    = bytes_left;
    pixels_left_next   = pixels_left;
    pack_register_next = pack_register;
    bit_position_next  = bit_position;
    frame_open_next    = frame_open;
    image_mode_next    = image_mode;
    run                = '0;
    case (opcode)
      bsfe_pkg::OP_MSG_HDR: begin
        if (!frame_open) begin
          run             = hdr_run;
          bytes_left_next = payload_length;
          image_mode_next = 1'b0;
          frame_open_next = (payload_length != 16'd0);
        end
      end
      bsfe_pkg::OP_IMG_HDR: begin
        if (!frame_open) begin
          run                = hdr_run;
          bytes_left_next    = hdr_len;
          pixels_left_next   = count_sat;
          pack_register_next = 8'h00;
          bit_position_next  = 3'd0;
          image_mode_next    = 1'b1;
          frame_open_next    = (count_sat != 19'd0);
        end
      end
      bsfe_pkg::OP_PAYLOAD: begin
        if (frame_open && !image_mode) begin
          run.data[0]     = single_esc.data[0];
          run.data[1]     = single_esc.data[1];
          run.len         = single_esc.two ? bsfe_pkg::RUN_LEN_W'(2) : bsfe_pkg::RUN_LEN_W'(1);
          run.ends_frame  = (bl_dec == 16'd0);
          bytes_left_next = bl_dec;
          frame_open_next = (bl_dec != 16'd0);
        end
      end
      bsfe_pkg::OP_PIXEL: begin
        if (frame_open && image_mode) begin
          pixels_left_next = pl_dec;
          if (bp_inc == 3'd0 || pl_dec == 19'd0) begin
            run.data[0]        = single_esc.data[0];
            run.data[1]        = single_esc.data[1];
            run.len            = single_esc.two ? bsfe_pkg::RUN_LEN_W'(2)
                                                : bsfe_pkg::RUN_LEN_W'(1);
            run.ends_frame     = (pl_dec == 19'd0);
            pack_register_next = 8'h00;
            bit_position_next  = 3'd0;
            bytes_left_next    = bl_dec;
            if (pl_dec == 19'd0) begin
              frame_open_next = 1'b0;
              image_mode_next = 1'b0;
              bytes_left_next = 16'd0;
            end
          end else begin
            pack_register_next = packed_byte;
            bit_position_next  = bp_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 16'd0;
      pixels_left   <= 19'd0;
      pack_register <= 8'h00;
      bit_position  <= 3'd0;
      frame_open    <= 1'b0;
      image_mode    <= 1'b0;
    end else if (accept) begin
      bytes_left    <= bytes_left_next;
      pixels_left   <= pixels_left_next;
      pack_register <= pack_register_next;
      bit_position  <= bit_position_next;
      frame_open    <= frame_open_next;
      image_mode    <= image_mode_next;
    end
  end

  assign status.frame_open  = frame_open;
  assign status.image_mode  = image_mode;
  assign status.bytes_zero  = (bytes_left == 16'd0);
  assign status.pixels_zero = (pixels_left == 19'd0);

endmodule

// File: sv/bsfe_run_buf.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder run buffer
// Holds one encoded run and shifts it out through the output register.
// ----------------------------------------------------------------------------
module bsfe_run_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bsfe_pkg::run_t    run_in,
  output bsfe_pkg::rstat_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_frame_end
);

  logic [bsfe_pkg::RUN_MAX-1:0][7:0] run_data;
  logic [bsfe_pkg::RUN_LEN_W-1:0]    run_len;
  logic [bsfe_pkg::RUN_LEN_W-1:0]    run_pos;
  logic                              run_end;

  logic pending, out_free, move, at_last;

  assign pending  = (run_pos != run_len);
  assign out_free = !out_valid || out_ready;
  assign move     = pending && out_free;
  assign at_last  = ((run_pos + bsfe_pkg::RUN_LEN_W'(1)) == run_len);

  assign status.pending = pending;
  assign status.free    = !pending || (move && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= '0;
      run_pos <= '0;
    end else if (load) begin
      run_len <= run_in.len;
      run_pos <= '0;
    end else if (move) begin
      run_pos <= run_pos + bsfe_pkg::RUN_LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_data <= run_in.data;
      run_end  <= run_in.ends_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte      <= run_data[run_pos];
      out_last      <= at_last;
      out_frame_end <= at_last && run_end;
    end
  end

endmodule

// File: sv/byte_stuffed_frame_encoder.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder
// Turns header, payload and pixel words into an escaped serial byte stream.
// ----------------------------------------------------------------------------
// Each accepted word is encoded in the cycle it is taken into a run of zero
// to nine output bytes, which a run buffer sends through a one-word output
// register, one byte per cycle unless m_axis_tready stalls it. A header gives
// five to nine bytes, a payload byte or a completed pixel byte gives one or
// two, and an ignored or mid-byte pixel word gives none. The slave side takes
// a new word whenever the run buffer is empty or is handing over its last
// byte, so words that make single bytes flow at one per cycle without stalls,
// and a longer run holds the input until its last byte is handed over. There
// is no clearing pass after reset. Configuration writes are taken in any
// cycle and must only be made while the encoder is idle.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_encoder_macros.svh"

module byte_stuffed_frame_encoder (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] frame_type, [15:8] frame_id, [31:16] payload_length,
  // [39:32] data_byte, [58:40] pixel_count, [59] pixel_on, [63:60] zero
  input  logic [63:0]                    s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                     s_axis_tuser,
  // output bytes
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]                     m_axis_tdata,
  output logic                           m_axis_tlast,   // last_of_run
  // [0] frame_end
  output logic                           m_axis_tuser,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic              accept;
  logic [7:0]        head_byte;
  logic [7:0]        image_command;
  bsfe_pkg::run_t    run;
  bsfe_pkg::fstat_t  fstat;
  bsfe_pkg::rstat_t  rstat;

  // Configuration port never stalls.
  assign cfg_ready = 1'b1;

  // Take a word when the run buffer will be free for the new run.
  assign s_axis_tready = rstat.free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bsfe_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_valid && cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .head_byte     (head_byte),
    .image_command (image_command)
  );

  // Encode the word against the current frame state and advance the state.
  bsfe_frame_ctl u_frame_ctl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (bsfe_pkg::opcode_t'(s_axis_tuser)),
    .frame_type     (s_axis_tdata[7:0]),
    .frame_id       (s_axis_tdata[15:8]),
    .payload_length (s_axis_tdata[31:16]),
    .data_byte      (s_axis_tdata[39:32]),
    .pixel_count    (s_axis_tdata[58:40]),
    .pixel_on       (s_axis_tdata[59]),
    .head_byte      (head_byte),
    .image_command  (image_command),
    .run            (run),
    .status         (fstat)
  );

  // Hold the run and drain it one byte per cycle while the output is not stalled.
  bsfe_run_buf u_run_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .run_in        (run),
    .status        (rstat),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_last      (m_axis_tlast),
    .out_frame_end (m_axis_tuser)
  );

  // A frame ends only on the last byte of a run.
  `BSFE_ASSERT_IMPL(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end without last of run")
  // With no run pending, a taken output word leaves the port empty next cycle.
  `BSFE_ASSERT_NEXT(a_drain_empty, m_axis_tvalid && m_axis_tready && !rstat.pending, !m_axis_tvalid, "output word without a pending run")
  // An open frame always has something left to send.
  `BSFE_ASSERT_NEVER(a_open_nonempty, fstat.frame_open && (fstat.image_mode ? fstat.pixels_zero : fstat.bytes_zero), "open frame with nothing left")

endmodule
